// ----- design/rgb_to_hsv_pixel_macros.svh -----
// Assertion macros shared by the RGB to HSV checker.
`ifndef RGB_TO_HSV_PIXEL_MACROS_SVH
`define RGB_TO_HSV_PIXEL_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RHSV_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rgb_to_hsv_pixel: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RHSV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rgb_to_hsv_pixel: next-cycle check failed");

`endif

// ----- design/rhsv_pkg.sv -----
// Shared widths, constants and types of the RGB to HSV converter.
package rhsv_pkg;

  localparam int CH_W        = 8;
  localparam int HUE_W       = 9;
  localparam int PCT_W       = 7;
  localparam int NUM_W       = 16;
  localparam int DEN_W       = 10;
  localparam int Q_W         = 7;
  localparam int DIV_STAGES  = Q_W;
  localparam int PIPE_STAGES = DIV_STAGES + 3;

  // Rounded division n/d is floor((2n + d) / 2d), so scales are doubled.
  localparam int SAT_SCALE = 200;
  localparam int HUE_SCALE = 120;
  localparam int VAL_SCALE = 200;
  localparam int VAL_BIAS  = 255;

  // The value numerator is divided by 510 through a multiply by the
  // rounded-up reciprocal of 510 with 25 fraction bits. This is exact for
  // every numerator the value path can produce.
  localparam int RCP_W     = 17;
  localparam int VAL_RECIP = 65794;
  localparam int VAL_SHIFT = 25;

  localparam int PCT_MAX   = 100;

  localparam int HUE_GREEN = 120;
  localparam int HUE_BLUE  = 240;
  localparam int HUE_FULL  = 360;

  typedef enum logic [2:0] {
    SEC_RED   = 3'b001,
    SEC_GREEN = 3'b010,
    SEC_BLUE  = 3'b100
  } sector_t;

  typedef struct packed {
    logic    grey;
    logic    neg;
    sector_t sector;
  } side_t;

endpackage

// ----- design/rhsv_div.sv -----
// Pipelined restoring divider, one quotient bit per register stage.
module rhsv_div import rhsv_pkg::*; (
  input  logic             clk,
  input  logic [Q_W-1:0]   en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   quo
);

  logic [NUM_W-1:0] rem_in [Q_W];
  logic [DEN_W-1:0] den_in [Q_W];
  logic [Q_W-1:0]   q_in   [Q_W];
  logic [NUM_W-1:0] rem_r  [Q_W];
  logic [DEN_W-1:0] den_r  [Q_W];
  logic [Q_W-1:0]   q_r    [Q_W];

  for (genvar j = 0; j < Q_W; j++) begin : g_stage
    logic [NUM_W-1:0] trial;
    logic             fits;

    if (j == 0) begin : g_first
      assign rem_in[j] = num;
      assign den_in[j] = den;
      assign q_in[j]   = '0;
    end else begin : g_next
      assign rem_in[j] = rem_r[j-1];
      assign den_in[j] = den_r[j-1];
      assign q_in[j]   = q_r[j-1];
    end

    // The quotient is known to stay below 2**Q_W, so the first trial
    // subtracts the divisor at weight 2**(Q_W-1).
    assign trial = NUM_W'(den_in[j]) << (Q_W - 1 - j);
    assign fits  = (rem_in[j] >= trial);

    always_ff @(posedge clk) begin
      if (en[j]) begin
        rem_r[j] <= fits ? (rem_in[j] - trial) : rem_in[j];
        den_r[j] <= den_in[j];
        q_r[j]   <= {q_in[j][Q_W-2:0], fits};
      end
    end
  end

  assign quo = q_r[Q_W-1];

endmodule

// ----- design/rgb_to_hsv_pixel.sv -----
// RGB to HSV converter: one pixel of 8-bit channels a cycle in, hue in
// degrees, saturation and value in percent out. The pipeline is ten
// register stages deep, and a new word is accepted every cycle while
// the output is taken. The depth is set by the two restoring dividers
// for saturation and hue, which produce one quotient bit per stage over
// seven stages; value divides by a constant and is taken by a reciprocal
// multiply that travels alongside. Each stage holds its word until the
// next stage frees up, so empty stages fill in while the output is
// stalled and nothing is dropped or repeated. The input stalls only when
// every stage is full and the output is stalled.
module rgb_to_hsv_pixel import rhsv_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [CH_W-1:0]  in_red,
  input  logic [CH_W-1:0]  in_green,
  input  logic [CH_W-1:0]  in_blue,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [HUE_W-1:0] out_hue,
  output logic [PCT_W-1:0] out_saturation,
  output logic [PCT_W-1:0] out_brightness
);

  localparam int LAST = PIPE_STAGES - 1;

  logic [PIPE_STAGES-1:0] en;
  logic [PIPE_STAGES-1:0] valid_r;
  logic [PIPE_STAGES-1:0] valid_nxt;

  // A stage may load when it is empty or its content moves on.
  always_comb begin
    en[LAST] = !valid_r[LAST] || !out_stall;
    for (int i = LAST - 1; i >= 0; i--) begin
      en[i] = !valid_r[i] || en[i+1];
    end
  end

  assign valid_nxt = {valid_r[LAST-1:0], in_valid};
  assign in_stall  = !en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      for (int i = 0; i < PIPE_STAGES; i++) begin
        if (en[i]) begin
          valid_r[i] <= valid_nxt[i];
        end
      end
    end
  end

  // Stage 0: max, min, sector and the signed channel difference.
  logic [CH_W-1:0] mx, mn, op_a, op_b;
  sector_t         sector;
  logic [CH_W-1:0] s0_mx_r, s0_delta_r, s0_mag_r;
  side_t           s0_side_r;

  always_comb begin
    mx = in_red;
    mn = in_red;
    if (in_green > mx) mx = in_green;
    if (in_blue > mx)  mx = in_blue;
    if (in_green < mn) mn = in_green;
    if (in_blue < mn)  mn = in_blue;
    priority if (in_red == mx) begin
      sector = SEC_RED;
      op_a   = in_green;
      op_b   = in_blue;
    end else if (in_green == mx) begin
      sector = SEC_GREEN;
      op_a   = in_blue;
      op_b   = in_red;
    end else begin
      sector = SEC_BLUE;
      op_a   = in_red;
      op_b   = in_green;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_mx_r          <= mx;
      s0_delta_r       <= mx - mn;
      s0_mag_r         <= (op_a >= op_b) ? (op_a - op_b) : (op_b - op_a);
      s0_side_r.grey   <= (mx == mn);
      s0_side_r.neg    <= (op_a < op_b);
      s0_side_r.sector <= sector;
    end
  end

  // Stage 1: numerators and divisors of the three rounded divisions.
  logic [NUM_W-1:0] s1_sat_num_r, s1_hue_num_r, s1_val_num_r;
  logic [DEN_W-1:0] s1_sat_den_r, s1_hue_den_r;
  side_t            s1_side_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_sat_num_r <= NUM_W'(SAT_SCALE) * NUM_W'(s0_delta_r) + NUM_W'(s0_mx_r);
      s1_sat_den_r <= DEN_W'({s0_mx_r, 1'b0});
      s1_hue_num_r <= NUM_W'(HUE_SCALE) * NUM_W'(s0_mag_r) + NUM_W'(s0_delta_r);
      s1_hue_den_r <= DEN_W'({s0_delta_r, 1'b0});
      s1_val_num_r <= NUM_W'(VAL_SCALE) * NUM_W'(s0_mx_r) + NUM_W'(VAL_BIAS);
      s1_side_r    <= s0_side_r;
    end
  end

  // Stages 2 to 8: the dividers, with the side bits and the value
  // traveling alongside.
  logic [Q_W-1:0]         sat_q, hue_q;
  side_t                  side_r [DIV_STAGES];
  logic [NUM_W+RCP_W-1:0] val_prod;
  logic [PCT_W-1:0]       val_r  [DIV_STAGES];

  rhsv_div u_sat_div (
    .clk (clk),
    .en  (en[DIV_STAGES+1:2]),
    .num (s1_sat_num_r),
    .den (s1_sat_den_r),
    .quo (sat_q)
  );

  rhsv_div u_hue_div (
    .clk (clk),
    .en  (en[DIV_STAGES+1:2]),
    .num (s1_hue_num_r),
    .den (s1_hue_den_r),
    .quo (hue_q)
  );

  assign val_prod = s1_val_num_r * RCP_W'(VAL_RECIP);

  always_ff @(posedge clk) begin
    for (int j = 0; j < DIV_STAGES; j++) begin
      if (en[j+2]) begin
        side_r[j] <= (j == 0) ? s1_side_r : side_r[(j == 0) ? 0 : j - 1];
        val_r[j]  <= (j == 0) ? val_prod[VAL_SHIFT +: PCT_W]
                              : val_r[(j == 0) ? 0 : j - 1];
      end
    end
  end

  // Last stage: add the sector offset and wrap a negative red hue.
  side_t            side_d;
  logic [HUE_W-1:0] hue_mag, hue_base, hue_nxt;
  logic [HUE_W-1:0] out_hue_r;
  logic [PCT_W-1:0] out_saturation_r, out_brightness_r;

  assign side_d  = side_r[DIV_STAGES-1];
  assign hue_mag = HUE_W'(hue_q);

  always_comb begin
    unique case (side_d.sector)
      SEC_RED:   hue_base = (side_d.neg && hue_mag != '0) ? HUE_W'(HUE_FULL) : '0;
      SEC_GREEN: hue_base = HUE_W'(HUE_GREEN);
      SEC_BLUE:  hue_base = HUE_W'(HUE_BLUE);
      default:   hue_base = '0;
    endcase
    hue_nxt = side_d.neg ? (hue_base - hue_mag) : (hue_base + hue_mag);
  end

  always_ff @(posedge clk) begin
    if (en[LAST]) begin
      out_hue_r        <= side_d.grey ? '0 : hue_nxt;
      out_saturation_r <= side_d.grey ? '0 : PCT_W'(sat_q);
      out_brightness_r <= val_r[DIV_STAGES-1];
    end
  end

  assign out_valid      = valid_r[LAST];
  assign out_hue        = out_hue_r;
  assign out_saturation = out_saturation_r;
  assign out_brightness = out_brightness_r;

endmodule

// ----- design/rhsv_checker.sv -----
// Port-level checker for the RGB to HSV converter and its bind.
`include "rgb_to_hsv_pixel_macros.svh"

module rhsv_checker import rhsv_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic [CH_W-1:0]  in_red,
  input logic [CH_W-1:0]  in_green,
  input logic [CH_W-1:0]  in_blue,
  input logic             out_valid,
  input logic             out_stall,
  input logic [HUE_W-1:0] out_hue,
  input logic [PCT_W-1:0] out_saturation,
  input logic [PCT_W-1:0] out_brightness
);

  logic                         out_in_range;
  logic [HUE_W+2*PCT_W-1:0]     out_word;

  assign out_in_range = (out_hue < HUE_W'(HUE_FULL)) && (out_saturation <= PCT_W'(PCT_MAX)) &&
                        (out_brightness <= PCT_W'(PCT_MAX));
  assign out_word     = {out_hue, out_saturation, out_brightness};

  // Results always lie in their documented ranges.
  `RHSV_ASSERT_SAME(a_out_range, clk, rst_n, out_valid, out_in_range)

  // With the output side moving, the pipeline always takes a new word.
  `RHSV_ASSERT_SAME(a_no_stall_free, clk, rst_n, !out_stall, !in_stall)

  // The input only backs up when the output holds a word that waits.
  `RHSV_ASSERT_SAME(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)

  // A stalled result stays put.
  `RHSV_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_word))

endmodule

bind rgb_to_hsv_pixel rhsv_checker u_rhsv_checker (.*);
